// ===== sv/uicc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the identifier character check: widths, table size
// and the sorted table of inclusive code point ranges. No dependencies.
package uicc_pkg;

    localparam int CP_W           = 21;
    localparam int TABLE_ENTRIES  = 175;
    localparam int RANGE_COUNT_DEFAULT = 175;
    localparam int BOUND_W        = 16;
    localparam int GROUP_SIZE     = 16;

    // Lower bounds, ascending; every range lies below 0x10000
    localparam logic [BOUND_W-1:0] RANGE_LO [0:TABLE_ENTRIES-1] = '{
        16'h0041, 16'h0061, 16'h00c0, 16'h00d8, 16'h00f8,
        16'h01fa, 16'h0250,
        16'h0384, 16'h0388, 16'h038c, 16'h038e, 16'h03a3,
        16'h03d0, 16'h03da, 16'h03dc, 16'h03de, 16'h03e0,
        16'h03e2,
        16'h0401, 16'h040f, 16'h0451, 16'h045e, 16'h0490,
        16'h04c7, 16'h04cb, 16'h04d0, 16'h04ee, 16'h04f8,
        16'h0531, 16'h0561,
        16'h05d0, 16'h05f0,
        16'h0621, 16'h0640, 16'h0670, 16'h06ba, 16'h06c0,
        16'h06e5,
        16'h0905, 16'h0958,
        16'h0985, 16'h098f, 16'h0993, 16'h09aa, 16'h09b2,
        16'h09b6, 16'h09dc, 16'h09df, 16'h09f0,
        16'h0a05, 16'h0a0f, 16'h0a13, 16'h0a2a, 16'h0a32,
        16'h0a35, 16'h0a38, 16'h0a59, 16'h0a5e,
        16'h0a85, 16'h0a8d, 16'h0a8f, 16'h0a93, 16'h0aaa,
        16'h0ab2, 16'h0ab5, 16'h0ae0,
        16'h0b05, 16'h0b0f, 16'h0b13, 16'h0b2a, 16'h0b32,
        16'h0b36, 16'h0b5c, 16'h0b5f,
        16'h0b85, 16'h0b8e, 16'h0b92, 16'h0b99, 16'h0b9c,
        16'h0b9e, 16'h0ba3, 16'h0ba8, 16'h0bae, 16'h0bb7,
        16'h0c05, 16'h0c0e, 16'h0c12, 16'h0c2a, 16'h0c35,
        16'h0c60,
        16'h0c85, 16'h0c8e, 16'h0c92, 16'h0caa, 16'h0cb5,
        16'h0ce0,
        16'h0d05, 16'h0d0e, 16'h0d12, 16'h0d2a, 16'h0d60,
        16'h0e01, 16'h0e32, 16'h0e40, 16'h0e4f,
        16'h0e81, 16'h0e84, 16'h0e87, 16'h0e88, 16'h0e8a,
        16'h0e8d, 16'h0e94, 16'h0e99, 16'h0ea1, 16'h0ea5,
        16'h0ea7, 16'h0eaa, 16'h0eab, 16'h0ead, 16'h0eb2,
        16'h0eb3, 16'h0ebd, 16'h0ec0, 16'h0ec6,
        16'h10a0, 16'h10d0,
        16'h1100, 16'h1161, 16'h11a8,
        16'h1e00, 16'h1ea0,
        16'h1f00, 16'h1f18, 16'h1f20, 16'h1f48, 16'h1f50,
        16'h1f59, 16'h1f5b, 16'h1f5d, 16'h1f5f, 16'h1f80,
        16'h1fb6, 16'h1fc2, 16'h1fc6, 16'h1fd0, 16'h1fd6,
        16'h1fe0, 16'h1ff2, 16'h1ff6,
        16'h3041, 16'h309b,
        16'h30a1,
        16'h3105,
        16'h4e00, 16'hf900, 16'hfb1f, 16'hfb38, 16'hfb3e,
        16'hfb40, 16'hfb42, 16'hfb46, 16'hfbd3, 16'hfd50,
        16'hfd92, 16'hfdf0, 16'hfe70, 16'hfe74, 16'hfe76,
        16'hff21, 16'hff41, 16'hff66, 16'hffc2, 16'hffca,
        16'hffd2, 16'hffda
    };

    // Upper bounds, inclusive, same order as the lower bounds
    localparam logic [BOUND_W-1:0] RANGE_HI [0:TABLE_ENTRIES-1] = '{
        16'h005a, 16'h007a, 16'h00d6, 16'h00f6, 16'h01f5,
        16'h0217, 16'h02a8,
        16'h0384, 16'h038a, 16'h038c, 16'h03a1, 16'h03ce,
        16'h03d6, 16'h03da, 16'h03dc, 16'h03de, 16'h03e0,
        16'h03f3,
        16'h040d, 16'h044f, 16'h045c, 16'h0481, 16'h04c4,
        16'h04c8, 16'h04cc, 16'h04eb, 16'h04f5, 16'h04f9,
        16'h0556, 16'h0587,
        16'h05ea, 16'h05f4,
        16'h063a, 16'h0652, 16'h06b7, 16'h06be, 16'h06ce,
        16'h06e7,
        16'h0939, 16'h0962,
        16'h098c, 16'h0990, 16'h09a8, 16'h09b0, 16'h09b2,
        16'h09b9, 16'h09dd, 16'h09e1, 16'h09f1,
        16'h0a0a, 16'h0a10, 16'h0a28, 16'h0a30, 16'h0a33,
        16'h0a36, 16'h0a39, 16'h0a5c, 16'h0a5e,
        16'h0a8b, 16'h0a8d, 16'h0a91, 16'h0aa8, 16'h0ab0,
        16'h0ab3, 16'h0ab9, 16'h0ae0,
        16'h0b0c, 16'h0b10, 16'h0b28, 16'h0b30, 16'h0b33,
        16'h0b39, 16'h0b5d, 16'h0b61,
        16'h0b8a, 16'h0b90, 16'h0b95, 16'h0b9a, 16'h0b9c,
        16'h0b9f, 16'h0ba4, 16'h0baa, 16'h0bb5, 16'h0bb9,
        16'h0c0c, 16'h0c10, 16'h0c28, 16'h0c33, 16'h0c39,
        16'h0c61,
        16'h0c8c, 16'h0c90, 16'h0ca8, 16'h0cb3, 16'h0cb9,
        16'h0ce1,
        16'h0d0c, 16'h0d10, 16'h0d28, 16'h0d39, 16'h0d61,
        16'h0e30, 16'h0e33, 16'h0e46, 16'h0e5b,
        16'h0e82, 16'h0e84, 16'h0e87, 16'h0e88, 16'h0e8a,
        16'h0e8d, 16'h0e97, 16'h0e9f, 16'h0ea3, 16'h0ea5,
        16'h0ea7, 16'h0eaa, 16'h0eab, 16'h0eb0, 16'h0eb2,
        16'h0eb3, 16'h0ebd, 16'h0ec4, 16'h0ec6,
        16'h10c5, 16'h10f6,
        16'h1159, 16'h11a2, 16'h11f9,
        16'h1e9a, 16'h1ef9,
        16'h1f15, 16'h1f1d, 16'h1f45, 16'h1f4d, 16'h1f57,
        16'h1f59, 16'h1f5b, 16'h1f5d, 16'h1f7d, 16'h1fb4,
        16'h1fbc, 16'h1fc4, 16'h1fcc, 16'h1fd3, 16'h1fdb,
        16'h1fec, 16'h1ff4, 16'h1ffc,
        16'h3094, 16'h309e,
        16'h30fe,
        16'h312c,
        16'h9fa5, 16'hfa2d, 16'hfb36, 16'hfb3c, 16'hfb3e,
        16'hfb41, 16'hfb44, 16'hfbb1, 16'hfd3f, 16'hfd8f,
        16'hfdc7, 16'hfdfb, 16'hfe72, 16'hfe74, 16'hfefc,
        16'hff3a, 16'hff5a, 16'hffbe, 16'hffc7, 16'hffcf,
        16'hffd7, 16'hffdc
    };

endpackage

// ===== sv/uicc_match.sv =====
`timescale 1ns / 1ps
// Range compare stage: checks one code point against the first N table ranges in
// parallel and registers one hit bit per range. Uses uicc_pkg.
module uicc_match
    import uicc_pkg::*;
#(
    parameter int N = RANGE_COUNT_DEFAULT
)
(
    input  logic            clk,
    input  logic            load,
    input  logic [CP_W-1:0] cp,
    output logic [N-1:0]    hit_reg
);

    logic [N-1:0] hit_next;
    logic         low_plane;

    // All ranges sit in the basic plane; upper bits must be zero
    assign low_plane = (cp[CP_W-1:BOUND_W] == '0);

    // Compare against each range bound pair
    for (genvar i = 0; i < N; i++) begin : g_cmp
        assign hit_next[i] = low_plane
                           && (cp[BOUND_W-1:0] >= RANGE_LO[i])
                           && (cp[BOUND_W-1:0] <= RANGE_HI[i]);
    end

    // Capture hit bits when the stage advances
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hit_reg <= hit_next;
        end
    end

endmodule

// ===== sv/uicc_reduce.sv =====
`timescale 1ns / 1ps
// Two-level registered OR tree over the per-range hit bits: group ORs,
// then the final OR that drives the result bit. Uses uicc_pkg.
module uicc_reduce
    import uicc_pkg::*;
#(
    parameter int N = RANGE_COUNT_DEFAULT
)
(
    input  logic         clk,
    input  logic         load_group,
    input  logic         load_final,
    input  logic [N-1:0] hit,
    output logic         any_reg
);

    localparam int NG = (N + GROUP_SIZE - 1) / GROUP_SIZE;

    logic [NG-1:0] group_next;
    logic [NG-1:0] group_reg;

    // OR each slice of hit bits; the last slice may be short
    for (genvar g = 0; g < NG; g++) begin : g_grp
        localparam int LO = g * GROUP_SIZE;
        localparam int HI = ((LO + GROUP_SIZE) < N) ? (LO + GROUP_SIZE - 1) : (N - 1);
        assign group_next[g] = |hit[HI:LO];
    end

    // Hold group ORs
    always_ff @(posedge clk)
    begin
        if (load_group)
        begin
            group_reg <= group_next;
        end
    end

    // Reduce groups into the result bit
    always_ff @(posedge clk)
    begin
        if (load_final)
        begin
            any_reg <= |group_reg;
        end
    end

endmodule

// ===== sv/unicode_identifier_char_check.sv =====
`timescale 1ns / 1ps
// Identifier character check: 1 word per cycle while out_ready stays high; each
// accepted word passes through the four register stages of the pipeline (input
// register, range compare, group OR, final OR) before the output is valid.
// Stalls back up stage by stage; empty stages fill while the output waits.
// Reset (rst_n, async, active low) clears all stage valid bits; no table init.
module unicode_identifier_char_check
    import uicc_pkg::*;
#(
    parameter int RANGE_COUNT = RANGE_COUNT_DEFAULT
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [CP_W-1:0] code_point,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            is_identifier_char
);

    localparam int N = (RANGE_COUNT < TABLE_ENTRIES) ? RANGE_COUNT : TABLE_ENTRIES;
    localparam int STAGES = 4;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES-1:0] en;
    logic [CP_W-1:0]   cp_reg;
    logic [N-1:0]      hit;

    // Advance a stage when it is empty or the next one advances
    assign en[3] = !v_reg[3] || out_ready;
    assign en[2] = !v_reg[2] || en[3];
    assign en[1] = !v_reg[1] || en[2];
    assign en[0] = !v_reg[0] || en[1];

    assign in_ready  = en[0];
    assign out_valid = v_reg[3];

    // Move valid bits with their words
    always_comb
    begin
        v_next[0] = en[0] ? in_valid : v_reg[0];
        v_next[1] = en[1] ? v_reg[0] : v_reg[1];
        v_next[2] = en[2] ? v_reg[1] : v_reg[2];
        v_next[3] = en[3] ? v_reg[2] : v_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            cp_reg <= code_point;
        end
    end

    uicc_match #(
        .N (N)
    ) u_match (
        .clk     (clk),
        .load    (en[1]),
        .cp      (cp_reg),
        .hit_reg (hit)
    );

    uicc_reduce #(
        .N (N)
    ) u_reduce (
        .clk        (clk),
        .load_group (en[2]),
        .load_final (en[3]),
        .hit        (hit),
        .any_reg    (is_identifier_char)
    );

`ifndef SYNTHESIS
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v_reg == {STAGES{1'b1}}))
        else $error("input blocked while a stage is empty");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v_reg[0])
        else $error("accepted word missing from first stage");

    a_first_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] && !en[1] |=> v_reg[0] && $stable(cp_reg))
        else $error("stalled first stage lost its word");

    a_mid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[2] && !en[3] |=> v_reg[2] && v_reg[3])
        else $error("stalled stage dropped a word");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for unicode_identifier_char_check: directed and random code points
// checked against an independent range table. Depends on uicc_pkg and the DUT.
module testbench;
    import uicc_pkg::*;

    localparam int TABLE_SIZE     = 175;
    localparam int CHECKED_RANGES = 175;
    localparam int STALL_LIMIT    = 1000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int MAX_PRINTED    = 20;

    // Identifier ranges, {low, high} inclusive, ascending
    localparam logic [31:0] ID_RANGES [0:TABLE_SIZE-1] = '{
        32'h0041_005a, 32'h0061_007a, 32'h00c0_00d6, 32'h00d8_00f6, 32'h00f8_01f5,
        32'h01fa_0217, 32'h0250_02a8,
        32'h0384_0384, 32'h0388_038a, 32'h038c_038c, 32'h038e_03a1, 32'h03a3_03ce,
        32'h03d0_03d6, 32'h03da_03da, 32'h03dc_03dc, 32'h03de_03de, 32'h03e0_03e0,
        32'h03e2_03f3,
        32'h0401_040d, 32'h040f_044f, 32'h0451_045c, 32'h045e_0481, 32'h0490_04c4,
        32'h04c7_04c8, 32'h04cb_04cc, 32'h04d0_04eb, 32'h04ee_04f5, 32'h04f8_04f9,
        32'h0531_0556, 32'h0561_0587,
        32'h05d0_05ea, 32'h05f0_05f4,
        32'h0621_063a, 32'h0640_0652, 32'h0670_06b7, 32'h06ba_06be, 32'h06c0_06ce,
        32'h06e5_06e7,
        32'h0905_0939, 32'h0958_0962,
        32'h0985_098c, 32'h098f_0990, 32'h0993_09a8, 32'h09aa_09b0, 32'h09b2_09b2,
        32'h09b6_09b9, 32'h09dc_09dd, 32'h09df_09e1, 32'h09f0_09f1,
        32'h0a05_0a0a, 32'h0a0f_0a10, 32'h0a13_0a28, 32'h0a2a_0a30, 32'h0a32_0a33,
        32'h0a35_0a36, 32'h0a38_0a39, 32'h0a59_0a5c, 32'h0a5e_0a5e,
        32'h0a85_0a8b, 32'h0a8d_0a8d, 32'h0a8f_0a91, 32'h0a93_0aa8, 32'h0aaa_0ab0,
        32'h0ab2_0ab3, 32'h0ab5_0ab9, 32'h0ae0_0ae0,
        32'h0b05_0b0c, 32'h0b0f_0b10, 32'h0b13_0b28, 32'h0b2a_0b30, 32'h0b32_0b33,
        32'h0b36_0b39, 32'h0b5c_0b5d, 32'h0b5f_0b61,
        32'h0b85_0b8a, 32'h0b8e_0b90, 32'h0b92_0b95, 32'h0b99_0b9a, 32'h0b9c_0b9c,
        32'h0b9e_0b9f, 32'h0ba3_0ba4, 32'h0ba8_0baa, 32'h0bae_0bb5, 32'h0bb7_0bb9,
        32'h0c05_0c0c, 32'h0c0e_0c10, 32'h0c12_0c28, 32'h0c2a_0c33, 32'h0c35_0c39,
        32'h0c60_0c61,
        32'h0c85_0c8c, 32'h0c8e_0c90, 32'h0c92_0ca8, 32'h0caa_0cb3, 32'h0cb5_0cb9,
        32'h0ce0_0ce1,
        32'h0d05_0d0c, 32'h0d0e_0d10, 32'h0d12_0d28, 32'h0d2a_0d39, 32'h0d60_0d61,
        32'h0e01_0e30, 32'h0e32_0e33, 32'h0e40_0e46, 32'h0e4f_0e5b,
        32'h0e81_0e82, 32'h0e84_0e84, 32'h0e87_0e87, 32'h0e88_0e88, 32'h0e8a_0e8a,
        32'h0e8d_0e8d, 32'h0e94_0e97, 32'h0e99_0e9f, 32'h0ea1_0ea3, 32'h0ea5_0ea5,
        32'h0ea7_0ea7, 32'h0eaa_0eaa, 32'h0eab_0eab, 32'h0ead_0eb0, 32'h0eb2_0eb2,
        32'h0eb3_0eb3, 32'h0ebd_0ebd, 32'h0ec0_0ec4, 32'h0ec6_0ec6,
        32'h10a0_10c5, 32'h10d0_10f6,
        32'h1100_1159, 32'h1161_11a2, 32'h11a8_11f9,
        32'h1e00_1e9a, 32'h1ea0_1ef9,
        32'h1f00_1f15, 32'h1f18_1f1d, 32'h1f20_1f45, 32'h1f48_1f4d, 32'h1f50_1f57,
        32'h1f59_1f59, 32'h1f5b_1f5b, 32'h1f5d_1f5d, 32'h1f5f_1f7d, 32'h1f80_1fb4,
        32'h1fb6_1fbc, 32'h1fc2_1fc4, 32'h1fc6_1fcc, 32'h1fd0_1fd3, 32'h1fd6_1fdb,
        32'h1fe0_1fec, 32'h1ff2_1ff4, 32'h1ff6_1ffc,
        32'h3041_3094, 32'h309b_309e,
        32'h30a1_30fe,
        32'h3105_312c,
        32'h4e00_9fa5, 32'hf900_fa2d, 32'hfb1f_fb36, 32'hfb38_fb3c, 32'hfb3e_fb3e,
        32'hfb40_fb41, 32'hfb42_fb44, 32'hfb46_fbb1, 32'hfbd3_fd3f, 32'hfd50_fd8f,
        32'hfd92_fdc7, 32'hfdf0_fdfb, 32'hfe70_fe72, 32'hfe74_fe74, 32'hfe76_fefc,
        32'hff21_ff3a, 32'hff41_ff5a, 32'hff66_ffbe, 32'hffc2_ffc7, 32'hffca_ffcf,
        32'hffd2_ffd7, 32'hffda_ffdc
    };

    logic            clk;
    logic            rst_n      = 1'b0;
    logic            in_valid   = 1'b0;
    logic            in_ready;
    logic [CP_W-1:0] code_point = '0;
    logic            out_valid;
    logic            out_ready  = 1'b0;
    logic            is_identifier_char;

    logic            expected_class_q [$];
    logic [CP_W-1:0] pending_cp_q [$];
    int              mismatch_count = 0;
    int              stall_cycles   = 0;
    bit              steady_flow    = 1'b0;

    unicode_identifier_char_check #(
        .RANGE_COUNT (CHECKED_RANGES)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .code_point         (code_point),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .is_identifier_char (is_identifier_char)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Classify one code point against the first CHECKED_RANGES table entries
    function automatic logic classify_code_point(input logic [CP_W-1:0] cp);
        int   limit;
        logic hit;
        limit = (CHECKED_RANGES < TABLE_SIZE) ? CHECKED_RANGES : TABLE_SIZE;
        hit   = 1'b0;
        for (int i = 0; i < limit; i++)
        begin
            if (cp >= CP_W'(ID_RANGES[i][31:16]) && cp <= CP_W'(ID_RANGES[i][15:0]))
                hit = 1'b1;
        end
        return hit;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Send one word; call at a falling edge, returns at a falling edge
    task automatic send_code_point(input logic [CP_W-1:0] cp);
        while (!steady_flow && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        code_point <= cp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_class_q.push_back(classify_code_point(cp));
        pending_cp_q.push_back(cp);
        @(negedge clk);
    endtask

    // Randomly stall the output side
    always @(negedge clk)
        out_ready <= steady_flow || ($urandom_range(99) >= 6);

    // Compare each delivered word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_class_q.size() == 0)
                report_mismatch($sformatf("unexpected word, is_identifier_char=%0b",
                                          is_identifier_char));
            else
            begin
                logic            want;
                logic [CP_W-1:0] cp;
                want = expected_class_q.pop_front();
                cp   = pending_cp_q.pop_front();
                if (is_identifier_char !== want)
                    report_mismatch($sformatf("code point %06h: is_identifier_char=%0b, want %0b",
                                              cp, is_identifier_char, want));
            end
        end
    end

    // Abort when neither channel moves a word for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // Field extremes, alternating bit patterns, table ends and special points
    task automatic test_directed_points();
        logic [CP_W-1:0] points [0:23] = '{
            21'h000000, 21'h1fffff, 21'h0aaaaa, 21'h155555,
            21'h000040, 21'h000041, 21'h00005a, 21'h00005b,
            21'h000060, 21'h000061, 21'h00007a, 21'h00007b,
            21'h000384, 21'h000e87, 21'h004e00, 21'h009fa5,
            21'h00fe76, 21'h00fefc, 21'h00ffdc, 21'h00ffdd,
            21'h00ffff, 21'h010000, 21'h10ffff, 21'h110000
        };
        foreach (points[i])
            send_code_point(points[i]);
    endtask

    // Hit both sides of randomly chosen range bounds, with no idling on either side
    task automatic test_range_edges();
        int              idx;
        logic [CP_W-1:0] bound;
        steady_flow = 1'b1;
        for (int n = 0; n < 500; n++)
        begin
            idx   = $urandom_range(TABLE_SIZE - 1);
            bound = $urandom_range(1) ? CP_W'(ID_RANGES[idx][31:16])
                                      : CP_W'(ID_RANGES[idx][15:0]);
            send_code_point(bound + CP_W'($urandom_range(2)) - CP_W'(1));
        end
        steady_flow = 1'b0;
    endtask

    // Uniform points over the basic plane, where every range lies
    task automatic test_bmp_random();
        for (int n = 0; n < 450; n++)
            send_code_point(CP_W'($urandom_range(16'hffff)));
    endtask

    // Points across all of Unicode and beyond it to the field limit
    task automatic test_full_width_random();
        for (int n = 0; n < 350; n++)
        begin
            if ($urandom_range(1))
                send_code_point(CP_W'($urandom_range(21'h10ffff)));
            else
                send_code_point(CP_W'($urandom));
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_points();
        test_range_edges();
        test_bmp_random();
        test_full_width_random();
        in_valid <= 1'b0;

        // Drain, then watch for stray words
        while (expected_class_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
